// ===== src/fmcm_pkg.sv =====
// Shared types and constants of the faulty memory cell model.
// Request/response payloads, configuration bundle, request and mode codes.
// No dependencies.
package fmcm_pkg;

    localparam int SEQ_MAX_DEF = 8;

    // Request codes
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // Fault modes
    localparam logic [1:0] FM_NONE  = 2'd0;
    localparam logic [1:0] FM_VALUE = 2'd1;
    localparam logic [1:0] FM_SEQ   = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_FAULT_MODE    = 3'd0;
    localparam logic [2:0] CFG_TRIGGER_VALUE = 3'd1;
    localparam logic [2:0] CFG_SEQ_LENGTH    = 3'd2;
    localparam logic [2:0] CFG_SEQ_KINDS     = 3'd3;
    localparam logic [2:0] CFG_SEQ_VALUES    = 3'd4;
    localparam logic [2:0] CFG_FAULT_CELL    = 3'd5;
    localparam logic [2:0] CFG_FAULT_READ    = 3'd6;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    // Cell value meaning "unknown"
    localparam logic signed [1:0] VAL_UNKNOWN = -2'sd1;

    typedef struct packed {
        logic [1:0] req_type;
        logic       data_value;
    } t_req;

    typedef struct packed {
        logic signed [1:0] read_result;
        logic              fault_fired;
    } t_rsp;

    typedef struct packed {
        logic [1:0]        fault_mode;
        logic signed [1:0] trigger_value;
        logic [3:0]        seq_length;
        logic [7:0]        seq_kinds;
        logic [7:0]        seq_values;
        logic signed [1:0] fault_cell_value;
        logic signed [1:0] fault_read_value;
    } t_cfg;

    // One history entry: access data, access kind, cell value before it
    typedef struct packed {
        logic              data;
        logic              kind;
        logic signed [1:0] prev_val;
    } t_hist;

endpackage

// ===== src/fmcm_cfg.sv =====
// Configuration register file of the faulty memory cell model.
// Depends on fmcm_pkg.
module fmcm_cfg
    import fmcm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FAULT_MODE:    n_cfg.fault_mode       = i_cfg_data[1:0];
                CFG_TRIGGER_VALUE: n_cfg.trigger_value    = i_cfg_data[1:0];
                CFG_SEQ_LENGTH:    n_cfg.seq_length       = i_cfg_data[3:0];
                CFG_SEQ_KINDS:     n_cfg.seq_kinds        = i_cfg_data;
                CFG_SEQ_VALUES:    n_cfg.seq_values       = i_cfg_data;
                CFG_FAULT_CELL:    n_cfg.fault_cell_value = i_cfg_data[1:0];
                CFG_FAULT_READ:    n_cfg.fault_read_value = i_cfg_data[1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fault_mode       <= FM_NONE;
            r_cfg.trigger_value    <= 2'sd0;
            r_cfg.seq_length       <= 4'd1;
            r_cfg.seq_kinds        <= 8'd0;
            r_cfg.seq_values       <= 8'd0;
            r_cfg.fault_cell_value <= VAL_UNKNOWN;
            r_cfg.fault_read_value <= VAL_UNKNOWN;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== src/fmcm_core.sv =====
// Cell state, access history and trigger evaluation.
// Computes the response of the request being accepted. Depends on fmcm_pkg.
module fmcm_core
    import fmcm_pkg::*;
#(
    parameter int SEQ_MAX = SEQ_MAX_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_acc,
    input  t_req i_req,
    input  t_cfg i_cfg,
    output t_rsp o_rsp
);

    localparam int          CNT_W     = $clog2(SEQ_MAX + 1);
    localparam logic [4:0]  SEQ_MAX_W = 5'(SEQ_MAX);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(SEQ_MAX);

    logic signed [1:0] r_cell;
    logic signed [1:0] n_cell;
    t_hist             r_win [SEQ_MAX];
    t_hist             n_win [SEQ_MAX];
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;

    logic              is_access;
    logic              is_read;
    logic              rec;
    logic [4:0]        len;
    logic [4:0]        pos;
    logic              seq_hit;
    logic              fired;
    t_hist             entry;

    always_comb begin
        is_access = (i_req.req_type == REQ_READ) || (i_req.req_type == REQ_WRITE);
        is_read   = (i_req.req_type == REQ_READ);
        rec       = is_access && (i_cfg.fault_mode == FM_SEQ);

        entry.data     = i_req.data_value;
        entry.kind     = (i_req.req_type == REQ_WRITE);
        entry.prev_val = r_cell;

        // Shift in the new access, newest at the front
        n_win[0] = entry;
        for (int j = 1; j < SEQ_MAX; j++) begin
            n_win[j] = r_win[j-1];
        end

        n_cnt = r_cnt;
        if (i_req.req_type == REQ_CLEAR) begin
            n_cnt = '0;
        end else if (rec && (r_cnt != CNT_MAX)) begin
            n_cnt = r_cnt + 1'b1;
        end

        // Effective sequence length, capped at the window depth
        len = ({1'b0, i_cfg.seq_length} > SEQ_MAX_W) ? SEQ_MAX_W : {1'b0, i_cfg.seq_length};

        seq_hit = (len != 5'd0) && (5'(n_cnt) >= len);
        pos     = '0;
        for (int j = 0; j < SEQ_MAX; j++) begin
            if (5'(j) < len) begin
                // Window slot j holds sequence access len-1-j
                pos = len - 5'd1 - 5'(j);
                if (pos < 5'd8) begin
                    if ((n_win[j].kind != i_cfg.seq_kinds[pos[2:0]]) ||
                        (n_win[j].data != i_cfg.seq_values[pos[2:0]])) begin
                        seq_hit = 1'b0;
                    end
                end else if (n_win[j].kind || n_win[j].data) begin
                    seq_hit = 1'b0;
                end
                if ((5'(j) == len - 5'd1) && (n_win[j].prev_val != i_cfg.trigger_value)) begin
                    seq_hit = 1'b0;
                end
            end
        end

        fired = 1'b0;
        if (is_access) begin
            case (i_cfg.fault_mode)
                FM_VALUE: fired = (r_cell == i_cfg.trigger_value);
                FM_SEQ:   fired = seq_hit;
                default:  fired = 1'b0;
            endcase
        end

        n_cell = r_cell;
        if (i_req.req_type == REQ_WRITE) begin
            n_cell = {1'b0, i_req.data_value};
        end
        if (fired) begin
            n_cell = i_cfg.fault_cell_value;
        end

        o_rsp.fault_fired = fired;
        o_rsp.read_result = VAL_UNKNOWN;
        if (is_read) begin
            if (!fired) begin
                o_rsp.read_result = r_cell;
            end else if (i_cfg.fault_read_value != VAL_UNKNOWN) begin
                o_rsp.read_result = i_cfg.fault_read_value;
            end else begin
                o_rsp.read_result = i_cfg.fault_cell_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= VAL_UNKNOWN;
            r_cnt  <= '0;
        end else if (i_acc) begin
            r_cell <= n_cell;
            r_cnt  <= n_cnt;
        end
    end

    // History payload: guarded by the count, needs no reset
    always_ff @(posedge i_clk) begin
        if (i_acc && rec) begin
            r_win <= n_win;
        end
    end

endmodule

// ===== src/fmcm_obuf.sv =====
// Output register with a skid stage for the response channel.
// Depends on fmcm_pkg.
module fmcm_obuf
    import fmcm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_rsp i_rsp,
    output logic o_full,
    output logic o_valid,
    input  logic i_stall,
    output t_rsp o_rsp
);

    logic r_out_v;
    logic r_skid_v;
    t_rsp r_out;
    t_rsp r_skid;
    logic in_acc;
    logic out_free;

    assign in_acc   = i_valid && !r_skid_v;
    assign out_free = !r_out_v || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (out_free) begin
            r_out_v  <= r_skid_v || in_acc;
            r_skid_v <= 1'b0;
        end else if (in_acc) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_v ? r_skid : i_rsp;
        end else if (in_acc) begin
            r_skid <= i_rsp;
        end
    end

    assign o_full  = r_skid_v;
    assign o_valid = r_out_v;
    assign o_rsp   = r_out;

endmodule

// ===== src/faulty_memory_cell_model_top.sv =====
// Top level of the faulty memory cell model.
// Instantiates fmcm_cfg, fmcm_core and fmcm_obuf; depends on fmcm_pkg.
//
// Usage:
//   Request channel: i_valid / o_stall carry one read, write or clear-history
//   request in i_req. A request is taken at a clock edge with i_valid high and
//   o_stall low. Response channel: o_valid / i_stall carry one response in
//   o_rsp per request, in request order.
//   Latency: the response shows on o_valid in the cycle after the request is
//   taken when the response side is free. The cell update, the history shift
//   and the trigger match all settle in the accept cycle, so one request per
//   cycle is sustained while the receiver does not stall.
//   Stall: when the receiver stalls, the held response stays put and one more
//   request is parked in a skid register; o_stall rises only while that skid
//   register is occupied, and drops the cycle after the receiver resumes.
//   Configuration: i_cfg_we writes register i_cfg_idx with i_cfg_data;
//   write only while no request is in flight.
//   Reset (i_rst_n low, synchronous): registers go to their reset values, the
//   cell becomes unknown, the history is emptied and both output stages clear.
module faulty_memory_cell_model_top
    import fmcm_pkg::*;
#(
    parameter int SEQ_MAX = SEQ_MAX_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_req                  i_req,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_rsp                  o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg cfg;
    t_rsp rsp;
    logic skid_full;
    logic req_acc;

    // Take a request whenever the skid stage has room
    assign req_acc = i_valid && !skid_full;
    assign o_stall = skid_full;

    fmcm_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Update cell state on every taken request; shift history on taken reads and writes in sequence mode
    fmcm_core #(
        .SEQ_MAX (SEQ_MAX)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (req_acc),
        .i_req   (i_req),
        .i_cfg   (cfg),
        .o_rsp   (rsp)
    );

    // Hold responses while the receiver stalls
    fmcm_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_rsp   (rsp),
        .o_full  (skid_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

endmodule

// ===== src/fmcm_chk.sv =====
// Port-level checker of the faulty memory cell model, bound to the top level.
// Depends on fmcm_pkg.
module fmcm_chk
    import fmcm_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_stall,
    input logic o_valid,
    input logic i_stall,
    input t_rsp o_rsp
);

    // Both output stages empty right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("output stages not empty after reset");

    // Skid occupied only behind a held response
    a_skid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("request stall without a pending response");

    // Skid fills only when the response side was stalled
    a_skid_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall && i_valid))
        else $error("request stall without a response stall");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("response dropped while stalled");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> $stable(o_rsp))
        else $error("response changed while stalled");

endmodule

bind faulty_memory_cell_model_top fmcm_chk u_fmcm_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_rsp   (o_rsp)
);

// ===== dv/fmcm_cell_checker.sv =====
// Response checker for the faulty memory cell model: watches both channels and the
// configuration port, predicts each response and compares it. Depends on fmcm_pkg.
module fmcm_cell_checker
    import fmcm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  logic                  i_req_stall,
    input  t_req                  i_req,
    input  logic                  i_rsp_valid,
    input  logic                  i_rsp_stall,
    input  t_rsp                  i_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [31:0]           o_fail_count,
    output logic [31:0]           o_pending
);

    localparam int SEQ_DEPTH = SEQ_MAX_DEF;
    localparam int EXP_DEPTH = 16;

    t_cfg              cell_cfg;
    logic signed [1:0] cell_state;
    t_hist             hist_win [SEQ_DEPTH];
    int                hist_count;
    t_rsp              exp_mem [EXP_DEPTH];
    int                exp_wr = 0;
    int                exp_rd = 0;
    int                exp_cnt = 0;
    int                fails = 0;
    int                rsp_seen = 0;

    initial begin
        o_fail_count = '0;
        o_pending    = '0;
    end

    // Advance the cell by one request and return the response it should give.
    function automatic t_rsp predict_access(input t_req r);
        t_rsp              res;
        logic signed [1:0] before_val;
        t_hist             ent;
        int                len;
        logic              hit;
        before_val      = cell_state;
        res.read_result = VAL_UNKNOWN;
        res.fault_fired = 1'b0;
        hit             = 1'b0;
        if (r.req_type == REQ_CLEAR) begin
            hist_count = 0;
        end else if (r.req_type == REQ_READ || r.req_type == REQ_WRITE) begin
            if (r.req_type == REQ_WRITE) begin
                cell_state = {1'b0, r.data_value};
            end
            if (cell_cfg.fault_mode == FM_VALUE) begin
                hit = (before_val == cell_cfg.trigger_value);
            end else if (cell_cfg.fault_mode == FM_SEQ) begin
                for (int i = SEQ_DEPTH - 1; i > 0; i--) begin
                    hist_win[i] = hist_win[i-1];
                end
                hist_win[0].data     = r.data_value;
                hist_win[0].kind     = r.req_type[0];
                hist_win[0].prev_val = before_val;
                if (hist_count < SEQ_DEPTH) begin
                    hist_count++;
                end
                len = (cell_cfg.seq_length > SEQ_DEPTH) ? SEQ_DEPTH : cell_cfg.seq_length;
                // Oldest access of the window sits at len-1 and pairs with sequence bit 0.
                if (len != 0 && hist_count >= len) begin
                    hit = (hist_win[len-1].prev_val == cell_cfg.trigger_value);
                    for (int i = 0; i < len; i++) begin
                        ent = hist_win[len-1-i];
                        if (ent.kind != cell_cfg.seq_kinds[i] ||
                            ent.data != cell_cfg.seq_values[i]) begin
                            hit = 1'b0;
                        end
                    end
                end
            end
            if (r.req_type == REQ_READ) begin
                res.read_result = cell_state;
            end
            if (hit) begin
                cell_state = cell_cfg.fault_cell_value;
                if (r.req_type == REQ_READ) begin
                    res.read_result = (cell_cfg.fault_read_value != VAL_UNKNOWN) ?
                                      cell_cfg.fault_read_value : cell_state;
                end
            end
            res.fault_fired = hit;
        end
        return res;
    endfunction

    task automatic note_mismatch(input t_rsp want, input logic have_want);
        fails++;
        if (fails <= 10) begin
            if (have_want) begin
                $display({"mismatch on response %0d: expected read_result=%0d ",
                          "fault_fired=%0b, got read_result=%0d fault_fired=%0b"},
                         rsp_seen, want.read_result, want.fault_fired,
                         i_rsp.read_result, i_rsp.fault_fired);
            end else begin
                $display({"response %0d with no request outstanding: ",
                          "read_result=%0d fault_fired=%0b"},
                         rsp_seen, i_rsp.read_result, i_rsp.fault_fired);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            cell_cfg.fault_mode       = FM_NONE;
            cell_cfg.trigger_value    = 2'sd0;
            cell_cfg.seq_length       = 4'd1;
            cell_cfg.seq_kinds        = 8'h00;
            cell_cfg.seq_values       = 8'h00;
            cell_cfg.fault_cell_value = VAL_UNKNOWN;
            cell_cfg.fault_read_value = VAL_UNKNOWN;
            cell_state                = VAL_UNKNOWN;
            hist_count                = 0;
            for (int i = 0; i < SEQ_DEPTH; i++) begin
                hist_win[i] = '0;
            end
            exp_wr  = 0;
            exp_rd  = 0;
            exp_cnt = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_FAULT_MODE:    cell_cfg.fault_mode       = i_cfg_data[1:0];
                    CFG_TRIGGER_VALUE: cell_cfg.trigger_value    = i_cfg_data[1:0];
                    CFG_SEQ_LENGTH:    cell_cfg.seq_length       = i_cfg_data[3:0];
                    CFG_SEQ_KINDS:     cell_cfg.seq_kinds        = i_cfg_data[7:0];
                    CFG_SEQ_VALUES:    cell_cfg.seq_values       = i_cfg_data[7:0];
                    CFG_FAULT_CELL:    cell_cfg.fault_cell_value = i_cfg_data[1:0];
                    CFG_FAULT_READ:    cell_cfg.fault_read_value = i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (i_req_valid && !i_req_stall) begin
                if (exp_cnt < EXP_DEPTH) begin
                    exp_mem[exp_wr] = predict_access(i_req);
                    exp_wr          = (exp_wr + 1) % EXP_DEPTH;
                    exp_cnt++;
                end else begin
                    // Far more requests outstanding than the block can hold
                    fails++;
                end
            end
            if (i_rsp_valid && !i_rsp_stall) begin
                if (exp_cnt == 0) begin
                    note_mismatch(want, 1'b0);
                end else begin
                    want   = exp_mem[exp_rd];
                    exp_rd = (exp_rd + 1) % EXP_DEPTH;
                    exp_cnt--;
                    if (i_rsp.read_result !== want.read_result ||
                        i_rsp.fault_fired !== want.fault_fired) begin
                        note_mismatch(want, 1'b1);
                    end
                end
                rsp_seen++;
            end
        end
        o_fail_count <= fails;
        o_pending    <= 32'(exp_cnt);
    end

endmodule

// ===== dv/faulty_memory_cell_model_top_tb.sv =====
// Testbench top for the faulty memory cell model: drives requests, configuration and response
// back-pressure and gives the verdict. Depends on fmcm_pkg, fmcm_cell_checker and the DUT top.
module faulty_memory_cell_model_top_tb;
    import fmcm_pkg::*;

    // Codes the package leaves unnamed; the block must ignore or tolerate them.
    localparam logic [1:0] REQ_UNUSED     = 2'd3;
    localparam logic [1:0] FM_UNUSED      = 2'd3;
    localparam logic [2:0] CFG_UNUSED_IDX = 3'd7;

    localparam int SEQ_DEPTH      = SEQ_MAX_DEF;
    localparam int RAND_ITEMS     = 750;
    localparam int HOLD_OFF       = 150;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  req_valid  = 1'b0;
    logic                  req_stall;
    t_req                  req        = '0;
    logic                  rsp_valid;
    logic                  rsp_stall  = 1'b0;
    t_rsp                  rsp;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic [31:0]           fail_count;
    logic [31:0]           rsp_pending;

    // Handshake between the request side and the response side for the long hold-off.
    logic pressure_go   = 1'b0;
    logic pressure_done = 1'b0;

    // Request-side bookkeeping
    int burst_left = 0;
    int items_sent = 0;
    int idle_cycles = 0;

    // Copy of the programmed registers, used to build sensitizing sequences
    logic [1:0] cur_mode;
    logic [1:0] cur_trig;
    logic [3:0] cur_len;
    logic [7:0] cur_kinds;
    logic [7:0] cur_vals;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    faulty_memory_cell_model_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (req_valid),
        .o_stall    (req_stall),
        .i_req      (req),
        .o_valid    (rsp_valid),
        .i_stall    (rsp_stall),
        .o_rsp      (rsp),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    fmcm_cell_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_stall  (req_stall),
        .i_req        (req),
        .i_rsp_valid  (rsp_valid),
        .i_rsp_stall  (rsp_stall),
        .i_rsp        (rsp),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (rsp_pending)
    );

    // Offer one request and hold it until the block takes it. Requests go out in
    // bursts; between bursts drop valid for a random gap and scramble the payload.
    task automatic push_req(input logic [1:0] kind, input logic wdata);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge clk);
                req_valid         = 1'b0;
                req.req_type      = 2'($urandom_range(0, 3));
                req.data_value    = 1'($urandom_range(0, 1));
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        @(negedge clk);
        req_valid      = 1'b1;
        req.req_type   = kind;
        req.data_value = wdata;
        // Accepted at the first rising edge that sees stall low.
        do @(posedge clk); while (req_stall);
        burst_left--;
        // Unused request codes change nothing, so leave them out of the count.
        if (kind != REQ_UNUSED) begin
            items_sent++;
        end
    endtask

    // Stop offering requests and wait until every response is back, then let the
    // block's output stages settle.
    task automatic settle_block();
        @(negedge clk);
        req_valid = 1'b0;
        while (rsp_pending != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
    endtask

    // Fill the bits above a register's width with noise; the block must drop them.
    function automatic logic [7:0] pad_cfg(input logic [7:0] value, input logic [7:0] mask);
        return (8'($urandom) & ~mask) | (value & mask);
    endfunction

    // Program every register while the block is idle.
    task automatic program_cell(input logic [1:0] mode, input logic [1:0] trig,
                                input logic [3:0] len, input logic [7:0] kinds,
                                input logic [7:0] vals, input logic [1:0] fcell,
                                input logic [1:0] fread);
        settle_block();
        cfg_write(CFG_FAULT_MODE,    pad_cfg({6'd0, mode},  8'h03));
        cfg_write(CFG_TRIGGER_VALUE, pad_cfg({6'd0, trig},  8'h03));
        cfg_write(CFG_SEQ_LENGTH,    pad_cfg({4'd0, len},   8'h0f));
        cfg_write(CFG_SEQ_KINDS,     kinds);
        cfg_write(CFG_SEQ_VALUES,    vals);
        cfg_write(CFG_FAULT_CELL,    pad_cfg({6'd0, fcell}, 8'h03));
        cfg_write(CFG_FAULT_READ,    pad_cfg({6'd0, fread}, 8'h03));
        @(negedge clk);
        cfg_we    = 1'b0;
        cur_mode  = mode;
        cur_trig  = trig;
        cur_len   = len;
        cur_kinds = kinds;
        cur_vals  = vals;
    endtask

    // Response side: stall on patterns of its own, in stretches of random length.
    // Once the request side asks for it, hold off for a long stretch so the skid
    // register fills and the block stalls its request channel.
    initial begin
        int pat;
        int stretch;
        int n;
        forever begin
            pat     = $urandom_range(0, 3);
            stretch = $urandom_range(5, 60);
            n       = 0;
            while (n < stretch && !(pressure_go && !pressure_done)) begin
                @(negedge clk);
                case (pat)
                    0: rsp_stall = 1'b0;
                    1: rsp_stall = 1'($urandom_range(0, 1));
                    2: rsp_stall = (n % 3 == 2);
                    default: rsp_stall = ($urandom_range(0, 9) < 8);
                endcase
                n++;
            end
            if (pressure_go && !pressure_done) begin
                pressure_done = 1'b1;
                @(negedge clk);
                rsp_stall = 1'b1;
                repeat (HOLD_OFF - 1) @(negedge clk);
            end
        end
    end

    // Watchdog: end the run if nothing moves on either channel for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int         rand_start;
        int         seg_target;
        int         seg_no;
        int         r;
        int         n_acc;
        int         flip_at;
        logic [1:0] kind;
        logic [1:0] mode_r;
        logic [3:0] len_r;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // A write to the unused register index must leave the block untouched.
        cfg_write(CFG_UNUSED_IDX, 8'($urandom));
        @(negedge clk);
        cfg_we = 1'b0;

        // No fault installed: the cell starts unknown, then plain reads and writes;
        // a clear and an unused request code both answer unknown.
        push_req(REQ_READ,   1'b0);
        push_req(REQ_WRITE,  1'b1);
        push_req(REQ_READ,   1'b1);
        push_req(REQ_WRITE,  1'b0);
        push_req(REQ_READ,   1'b0);
        push_req(REQ_CLEAR,  1'b0);
        push_req(REQ_UNUSED, 1'b1);
        push_req(REQ_READ,   1'b1);

        // Value trigger on 0, force to 1, triggering read returns the cell.
        program_cell(FM_VALUE, 2'b00, 4'd1, 8'h00, 8'h00, 2'b01, 2'b11);
        push_req(REQ_WRITE, 1'b1);
        push_req(REQ_READ,  1'b0);
        push_req(REQ_WRITE, 1'b0);
        push_req(REQ_READ,  1'b1);

        // Out of range pattern for the forced value and a fixed read value of 0.
        program_cell(FM_VALUE, 2'b01, 4'd1, 8'h00, 8'h00, 2'b10, 2'b00);
        push_req(REQ_READ, 1'b0);
        // Out of range trigger, matched by the out of range cell it just forced.
        program_cell(FM_VALUE, 2'b10, 4'd1, 8'h00, 8'h00, 2'b10, 2'b10);
        push_req(REQ_READ, 1'b1);

        // Sequence trigger: write 1 found at 0, then read with data 1.
        program_cell(FM_SEQ, 2'b00, 4'd2, 8'h01, 8'h03, 2'b00, 2'b11);
        push_req(REQ_CLEAR, 1'b1);
        push_req(REQ_WRITE, 1'b0);
        push_req(REQ_WRITE, 1'b1);
        push_req(REQ_READ,  1'b1);

        // Unused fault mode acts as no fault.
        program_cell(FM_UNUSED, 2'b00, 4'd1, 8'h00, 8'h00, 2'b01, 2'b01);
        push_req(REQ_WRITE, 1'b0);
        push_req(REQ_READ,  1'b1);

        // Force the cell unknown, then trigger on an unknown cell.
        program_cell(FM_VALUE, 2'b00, 4'd1, 8'h00, 8'h00, 2'b11, 2'b01);
        push_req(REQ_READ, 1'b0);
        program_cell(FM_VALUE, 2'b11, 4'd15, 8'hff, 8'hff, 2'b11, 2'b01);
        push_req(REQ_READ, 1'b1);

        // Random segments, each under a fresh register setting.
        rand_start = items_sent;
        seg_no     = 0;
        while (items_sent - rand_start < RAND_ITEMS) begin
            r = $urandom_range(0, 9);
            mode_r = (r < 1) ? FM_NONE : (r < 4) ? FM_VALUE : (r < 9) ? FM_SEQ : FM_UNUSED;
            r = $urandom_range(0, 9);
            len_r = (r < 7) ? 4'($urandom_range(1, 4)) :
                    (r == 7) ? 4'(SEQ_DEPTH) :
                    (r == 8) ? 4'd0 : 4'($urandom_range(9, 15));
            program_cell(mode_r, 2'($urandom), len_r, 8'($urandom), 8'($urandom),
                         2'($urandom), 2'($urandom));
            // Keep offering requests through the long response hold-off.
            if (seg_no == 2) begin
                pressure_go = 1'b1;
            end
            seg_target = items_sent + $urandom_range(40, 80);
            while (items_sent < seg_target) begin
                if (cur_mode == FM_SEQ && cur_len != 0 && $urandom_range(0, 3) != 0) begin
                    // Well-formed sensitizing sequence, sometimes with one data bit broken.
                    n_acc   = (cur_len > SEQ_DEPTH) ? SEQ_DEPTH : cur_len;
                    flip_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n_acc - 1) : -1;
                    if ($urandom_range(0, 1)) begin
                        push_req(REQ_CLEAR, 1'($urandom_range(0, 1)));
                    end
                    // Set up the before-value of the oldest access when it is a real level.
                    if (!cur_trig[1]) begin
                        push_req(REQ_WRITE, cur_trig[0]);
                    end
                    for (int k = 0; k < n_acc; k++) begin
                        push_req(cur_kinds[k] ? REQ_WRITE : REQ_READ,
                                 cur_vals[k] ^ (k == flip_at));
                    end
                end else begin
                    // Noise: any request code with random data.
                    r    = $urandom_range(0, 9);
                    kind = (r < 4) ? REQ_READ : (r < 8) ? REQ_WRITE :
                           (r == 8) ? REQ_CLEAR : REQ_UNUSED;
                    push_req(kind, 1'($urandom_range(0, 1)));
                end
            end
            seg_no++;
        end

        settle_block();
        if (fail_count == 0 && rsp_pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/fmcm_pkg.sv
src/fmcm_cfg.sv
src/fmcm_core.sv
src/fmcm_obuf.sv
src/faulty_memory_cell_model_top.sv
src/fmcm_chk.sv
dv/fmcm_cell_checker.sv
dv/faulty_memory_cell_model_top_tb.sv
